@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the name token cache.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define NTLC_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ntlc: assertion failed");

// Next-cycle implication under an active-low reset.
`define NTLC_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ntlc: assertion failed");

`endif

@@ rtl/core/ntlc_pkg.sv @@
// Package of the name token cache: sizes, operation codes and word types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ntlc_pkg;

    localparam int ENTRIES     = 8;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int ROW_BITS    = 16;
    localparam int GEN_BITS    = 32;
    localparam int HASH_W      = 64;
    localparam int FUNC_W      = 3;
    localparam int SLOT_W      = 3;
    localparam int STAMP_W     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_BUMP   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVICT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RECORD = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    typedef enum logic [2:0] {
        OP_LOOKUP,
        OP_BUMP,
        OP_EVICT,
        OP_RECORD,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] key_hash;
        logic [15:0] row_number;
        logic [31:0] generation;
        logic [2:0]  slot;
    } in_word_t;

    typedef struct packed {
        logic        hit;
        logic [2:0]  hit_slot;
        logic [15:0] hit_row;
        logic [31:0] hit_generation;
        logic [3:0]  used_count;
    } out_word_t;

    typedef struct packed {
        op_t                 op;
        logic                slot_ok;
        logic [IDX_W-1:0]    idx;
        logic [HASH_W-1:0]   hash;
        logic [ROW_BITS-1:0] row;
        logic [GEN_BITS-1:0] gen;
    } cmd_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } back_status_t;

endpackage

@@ rtl/core/ntlc_front.sv @@
// Front end of the name token cache: takes input words and decodes them into commands.
// Depends on ntlc_pkg.
`timescale 1ns / 1ps

module ntlc_front
    import ntlc_pkg::*;
(
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    input  logic     q_full,
    output logic     push,
    output cmd_t     push_cmd
);

    op_t op;

    always_comb
    begin
        case (in_word.func)
            FUNC_LOOKUP: op = OP_LOOKUP;
            FUNC_BUMP:   op = OP_BUMP;
            FUNC_EVICT:  op = OP_EVICT;
            FUNC_RECORD: op = OP_RECORD;
            FUNC_CLEAR:  op = OP_CLEAR;
            default:     op = OP_NOP;
        endcase
    end

    assign in_ready         = !q_full;
    assign push             = in_valid && !q_full;
    assign push_cmd.op      = op;
    assign push_cmd.slot_ok = {1'b0, in_word.slot} < (SLOT_W + 1)'(ENTRIES);
    assign push_cmd.idx     = IDX_W'(in_word.slot);
    assign push_cmd.hash    = in_word.key_hash;
    assign push_cmd.row     = ROW_BITS'(in_word.row_number);
    assign push_cmd.gen     = GEN_BITS'(in_word.generation);

endmodule

@@ rtl/core/ntlc_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on ntlc_pkg.
`timescale 1ns / 1ps

module ntlc_queue
    import ntlc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic q_valid,
    output cmd_t q_cmd,
    input  logic pop
);

    cmd_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_cmd   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/ntlc_back.sv @@
// Back end of the name token cache: entry store, scan sequencer and output register.
// Depends on ntlc_pkg.
`timescale 1ns / 1ps

module ntlc_back
    import ntlc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  cmd_t         q_cmd,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output out_word_t    out_word,
    output back_status_t status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DONE
    } state_t;

    logic [HASH_W-1:0]   hash_mem  [ENTRIES];
    logic [ROW_BITS-1:0] row_mem   [ENTRIES];
    logic [GEN_BITS-1:0] gen_mem   [ENTRIES];
    logic [STAMP_W-1:0]  stamp_mem [ENTRIES];

    state_t              state_reg,       state_next;
    cmd_t                cmd_reg,         cmd_next;
    logic [IDX_W-1:0]    idx_reg,         idx_next;
    logic [ENTRIES-1:0]  valid_reg,       valid_next;
    logic [CNT_W-1:0]    count_reg,       count_next;
    logic [STAMP_W-1:0]  age_clock_reg,   age_clock_next;
    logic                match_found_reg, match_found_next;
    logic [IDX_W-1:0]    match_idx_reg,   match_idx_next;
    logic                empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]    empty_idx_reg,   empty_idx_next;
    logic [STAMP_W-1:0]  best_age_reg,    best_age_next;
    logic [IDX_W-1:0]    best_idx_reg,    best_idx_next;
    logic                res_hit_reg,     res_hit_next;
    logic [IDX_W-1:0]    res_slot_reg,    res_slot_next;
    logic [ROW_BITS-1:0] res_row_reg,     res_row_next;
    logic [GEN_BITS-1:0] res_gen_reg,     res_gen_next;
    logic                out_valid_reg,   out_valid_next;
    out_word_t           out_word_reg,    out_word_next;

    logic [HASH_W-1:0]   rd_hash_reg;
    logic [ROW_BITS-1:0] rd_row_reg;
    logic [GEN_BITS-1:0] rd_gen_reg;
    logic [STAMP_W-1:0]  rd_stamp_reg;

    logic                rd_valid;
    logic [STAMP_W-1:0]  age;
    logic [STAMP_W-1:0]  age_inc;
    logic                last;
    logic [IDX_W-1:0]    tgt;
    logic                wr_stamp;
    logic                wr_hash;
    logic                wr_tok;
    logic [IDX_W-1:0]    wr_idx;

    assign rd_valid = valid_reg[idx_reg];
    assign age      = age_clock_reg - rd_stamp_reg;
    assign age_inc  = age_clock_reg + 1'b1;
    assign last     = idx_reg == IDX_W'(ENTRIES - 1);
    assign tgt      = match_found_reg ? match_idx_reg :
                      (empty_found_reg ? empty_idx_reg : best_idx_reg);

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        idx_next         = idx_reg;
        valid_next       = valid_reg;
        count_next       = count_reg;
        age_clock_next   = age_clock_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        best_age_next    = best_age_reg;
        best_idx_next    = best_idx_reg;
        res_hit_next     = res_hit_reg;
        res_slot_next    = res_slot_reg;
        res_row_next     = res_row_reg;
        res_gen_next     = res_gen_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_word_next    = out_word_reg;
        q_pop            = 1'b0;
        wr_stamp         = 1'b0;
        wr_hash          = 1'b0;
        wr_tok           = 1'b0;
        wr_idx           = cmd_reg.idx;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop            = 1'b1;
                    cmd_next         = q_cmd;
                    idx_next         = (q_cmd.op == OP_LOOKUP) ? q_cmd.idx : '0;
                    match_found_next = 1'b0;
                    empty_found_next = 1'b0;
                    best_age_next    = '0;
                    best_idx_next    = '0;
                    res_hit_next     = 1'b0;
                    res_slot_next    = '0;
                    res_row_next     = '0;
                    res_gen_next     = '0;
                    case (q_cmd.op)
                        OP_LOOKUP: state_next = q_cmd.slot_ok ? S_SCAN : S_DONE;
                        OP_RECORD: state_next = S_SCAN;
                        default:   state_next = S_APPLY;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cmd_reg.op == OP_LOOKUP)
                begin
                    if (rd_valid && rd_hash_reg == cmd_reg.hash)
                    begin
                        res_hit_next  = 1'b1;
                        res_slot_next = idx_reg;
                        res_row_next  = rd_row_reg;
                        res_gen_next  = rd_gen_reg;
                        state_next    = S_DONE;
                    end
                    else if (last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (!match_found_reg && rd_valid && rd_row_reg == cmd_reg.row &&
                        rd_gen_reg == cmd_reg.gen)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = idx_reg;
                    end
                    if (!empty_found_reg && !rd_valid)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = idx_reg;
                    end
                    if (idx_reg == '0 || age > best_age_reg)
                    begin
                        best_age_next = age;
                        best_idx_next = idx_reg;
                    end
                    if (last)
                    begin
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_APPLY:
            begin
                state_next = S_DONE;
                case (cmd_reg.op)
                    OP_BUMP:
                    begin
                        if (cmd_reg.slot_ok && valid_reg[cmd_reg.idx])
                        begin
                            age_clock_next = age_inc;
                            wr_stamp       = 1'b1;
                        end
                    end
                    OP_EVICT:
                    begin
                        if (cmd_reg.slot_ok && valid_reg[cmd_reg.idx])
                        begin
                            valid_next[cmd_reg.idx] = 1'b0;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                    OP_CLEAR:
                    begin
                        valid_next     = '0;
                        count_next     = '0;
                        age_clock_next = STAMP_W'(1);
                    end
                    OP_RECORD:
                    begin
                        wr_idx         = tgt;
                        age_clock_next = age_inc;
                        wr_stamp       = 1'b1;
                        wr_hash        = 1'b1;
                        res_slot_next  = tgt;
                        res_row_next   = cmd_reg.row;
                        res_gen_next   = cmd_reg.gen;
                        if (!match_found_reg)
                        begin
                            wr_tok           = 1'b1;
                            valid_next[tgt]  = 1'b1;
                            if (empty_found_reg)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next               = 1'b1;
                    out_word_next.hit            = res_hit_reg;
                    out_word_next.hit_slot       = 3'(res_slot_reg);
                    out_word_next.hit_row        = 16'(res_row_reg);
                    out_word_next.hit_generation = 32'(res_gen_reg);
                    out_word_next.used_count     = 4'(count_reg);
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= '0;
            idx_reg         <= '0;
            valid_reg       <= '0;
            count_reg       <= '0;
            age_clock_reg   <= STAMP_W'(1);
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            best_age_reg    <= '0;
            best_idx_reg    <= '0;
            res_hit_reg     <= 1'b0;
            res_slot_reg    <= '0;
            res_row_reg     <= '0;
            res_gen_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_word_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            idx_reg         <= idx_next;
            valid_reg       <= valid_next;
            count_reg       <= count_next;
            age_clock_reg   <= age_clock_next;
            match_found_reg <= match_found_next;
            match_idx_reg   <= match_idx_next;
            empty_found_reg <= empty_found_next;
            empty_idx_reg   <= empty_idx_next;
            best_age_reg    <= best_age_next;
            best_idx_reg    <= best_idx_next;
            res_hit_reg     <= res_hit_next;
            res_slot_reg    <= res_slot_next;
            res_row_reg     <= res_row_next;
            res_gen_reg     <= res_gen_next;
            out_valid_reg   <= out_valid_next;
            out_word_reg    <= out_word_next;
        end
    end

    // The entry at the next scan index is read into the read registers, so they hold the entry at the current index.
    always_ff @(posedge clk)
    begin
        rd_hash_reg  <= hash_mem[idx_next];
        rd_row_reg   <= row_mem[idx_next];
        rd_gen_reg   <= gen_mem[idx_next];
        rd_stamp_reg <= stamp_mem[idx_next];
        if (wr_stamp)
        begin
            stamp_mem[wr_idx] <= age_inc;
        end
        if (wr_hash)
        begin
            hash_mem[wr_idx] <= cmd_reg.hash;
        end
        if (wr_tok)
        begin
            row_mem[wr_idx] <= cmd_reg.row;
            gen_mem[wr_idx] <= cmd_reg.gen;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_word     = out_word_reg;
    assign status.busy  = state_reg != S_IDLE;
    assign status.count = count_reg;

endmodule

@@ rtl/core/name_token_lru_cache_unit.sv @@
// Top level of the name token cache: front decoder, command queue and back end.
// Depends on ntlc_pkg, ntlc_front, ntlc_queue, ntlc_back and assert_macros.svh.
//
//   Channel   Handshake                Word
//   input     in_valid / in_ready      in_word  (in_word_t)
//   output    out_valid / out_ready    out_word (out_word_t)
//
// The back end scans one entry per cycle: a lookup from its slot index up to a hit or the
// last entry, a record over every entry; record, bump, evict, clear and unused codes pass the apply state.
// Reset clears the valid bits and the count and sets the age clock to one at once; no clearing pass.
// A two-word queue keeps taking input, until it is full, while the back end works or the output stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module name_token_lru_cache_unit
    import ntlc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic         push;
    cmd_t         push_cmd;
    logic         q_full;
    logic         q_valid;
    cmd_t         q_cmd;
    logic         q_pop;
    back_status_t back_status;

    ntlc_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ntlc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (q_pop)
    );

    ntlc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .status    (back_status)
    );

    `NTLC_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, back_status.count <= CNT_W'(ENTRIES))
    `NTLC_ASSERT_IMPL(a_hit_has_entry, clk, rst_n, out_valid && out_word.hit, out_word.used_count != 4'd0)
    `NTLC_ASSERT_NEXT(a_pop_starts_work, clk, rst_n, q_pop, back_status.busy)

endmodule

@@ tb/ntlc_token_checker.sv @@
// Checker for the name token cache: keeps its own copy of the cache, predicts a reply
// word for every accepted request word and compares it with the reply the block returns.
// Depends on ntlc_pkg; instantiated beside the block by name_token_lru_cache_unit_tb.
`timescale 1ns / 1ps

module ntlc_token_checker
    import ntlc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_word,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_word,
    output int        mismatches,
    output int        replies_checked,
    output int        replies_awaited
);

    logic                slot_used  [ENTRIES];
    logic [HASH_W-1:0]   slot_hash  [ENTRIES];
    logic [ROW_BITS-1:0] slot_row   [ENTRIES];
    logic [GEN_BITS-1:0] slot_gen   [ENTRIES];
    logic [STAMP_W-1:0]  slot_stamp [ENTRIES];
    int unsigned         used_entries;
    logic [STAMP_W-1:0]  age_tick;

    out_word_t predicted_replies [$];

    function automatic void wipe_slot(int i);
        slot_used[i]  = 1'b0;
        slot_hash[i]  = '0;
        slot_row[i]   = '0;
        slot_gen[i]   = '0;
        slot_stamp[i] = '0;
    endfunction

    function automatic void flush_cache();
        for (int i = 0; i < ENTRIES; i++)
            wipe_slot(i);
        used_entries = 0;
        age_tick     = STAMP_W'(1);
    endfunction

    function automatic void touch_slot(int i);
        age_tick      = age_tick + 1'b1;
        slot_stamp[i] = age_tick;
    endfunction

    function automatic out_word_t apply_cache_op(in_word_t w);
        out_word_t          r;
        int                 target;
        logic [STAMP_W-1:0] age;
        logic [STAMP_W-1:0] oldest;
        r      = '0;
        target = -1;
        oldest = '0;
        case (w.func)
            FUNC_LOOKUP:
            begin
                for (int i = int'(w.slot); i < ENTRIES; i++) begin
                    if (!r.hit && slot_used[i] && slot_hash[i] == w.key_hash) begin
                        r.hit            = 1'b1;
                        r.hit_slot       = i[SLOT_W-1:0];
                        r.hit_row        = slot_row[i];
                        r.hit_generation = slot_gen[i];
                    end
                end
            end
            FUNC_BUMP:
            begin
                if (slot_used[w.slot])
                    touch_slot(int'(w.slot));
            end
            FUNC_EVICT:
            begin
                if (slot_used[w.slot]) begin
                    wipe_slot(int'(w.slot));
                    if (used_entries > 0)
                        used_entries--;
                end
            end
            FUNC_RECORD:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (target < 0 && slot_used[i] && slot_row[i] == w.row_number &&
                        slot_gen[i] == w.generation)
                        target = i;
                if (target >= 0) begin
                    touch_slot(target);
                    slot_hash[target] = w.key_hash;
                end
                else begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (target < 0 && !slot_used[i])
                            target = i;
                    if (target >= 0) begin
                        used_entries++;
                    end
                    else begin
                        // The oldest entry by wrap-safe age goes; the lowest slot wins a tie.
                        for (int i = 0; i < ENTRIES; i++) begin
                            age = age_tick - slot_stamp[i];
                            if (target < 0 || age > oldest) begin
                                oldest = age;
                                target = i;
                            end
                        end
                    end
                    touch_slot(target);
                    slot_used[target] = 1'b1;
                    slot_hash[target] = w.key_hash;
                    slot_row[target]  = w.row_number;
                    slot_gen[target]  = w.generation;
                end
                r.hit_slot       = target[SLOT_W-1:0];
                r.hit_row        = slot_row[target];
                r.hit_generation = slot_gen[target];
            end
            FUNC_CLEAR:
            begin
                flush_cache();
            end
            default:
            begin
            end
        endcase
        r.used_count = used_entries[3:0];
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_word_t want;
        if (!rst_n) begin
            flush_cache();
            predicted_replies.delete();
            mismatches      = 0;
            replies_checked = 0;
            replies_awaited <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (predicted_replies.size() == 0) begin
                    $error("reply word %0h arrived with no request outstanding", out_word);
                    mismatches++;
                end
                else begin
                    want = predicted_replies.pop_front();
                    check_field("hit", want.hit, out_word.hit);
                    check_field("hit_slot", want.hit_slot, out_word.hit_slot);
                    check_field("hit_row", want.hit_row, out_word.hit_row);
                    check_field("hit_generation", want.hit_generation,
                                out_word.hit_generation);
                    check_field("used_count", want.used_count, out_word.used_count);
                    replies_checked++;
                end
            end
            if (in_valid && in_ready)
                predicted_replies.push_back(apply_cache_op(in_word));
            replies_awaited <= predicted_replies.size();
        end
    end

endmodule

@@ tb/name_token_lru_cache_unit_tb.sv @@
// Top of the name token cache testbench: clock, reset, request words and reply stalls.
// Depends on ntlc_pkg, name_token_lru_cache_unit and ntlc_token_checker.
`timescale 1ns / 1ps

module name_token_lru_cache_unit_tb;
    import ntlc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = FUNC_CLEAR + 1'b1;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = '1;
    localparam int RANDOM_ITEMS = 1650;
    localparam int AGING_BUMPS  = 64;
    localparam int HASH_POOL    = 8;
    localparam int TOKEN_POOL   = 12;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;

    typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    in_word_t  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    out_word_t out_word;

    int mismatches;
    int replies_checked;
    int replies_awaited;
    int cycle_count = 0;
    int burst_left  = 0;
    int op_tally [1 << FUNC_W] = '{default: 0};

    int          rx_run  = 0;
    rx_pattern_t rx_mode = RX_OPEN;

    logic [HASH_W-1:0]   hash_pool  [HASH_POOL];
    logic [ROW_BITS-1:0] token_row  [TOKEN_POOL];
    logic [GEN_BITS-1:0] token_gen  [TOKEN_POOL];

    name_token_lru_cache_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    ntlc_token_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_word         (in_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_word        (out_word),
        .mismatches      (mismatches),
        .replies_checked (replies_checked),
        .replies_awaited (replies_awaited)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rx_run == 0) begin
            rx_run  <= $urandom_range(1, 40);
            rx_mode <= rx_pattern_t'($urandom_range(0, 3));
        end
        else begin
            rx_run <= rx_run - 1;
        end
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= ~out_ready;
        endcase
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles.", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [HASH_W-1:0] random_hash();
        return {$urandom(), $urandom()};
    endfunction

    function automatic in_word_t make_word(logic [FUNC_W-1:0] f, logic [HASH_W-1:0] h,
                                           logic [ROW_BITS-1:0] r, logic [GEN_BITS-1:0] g,
                                           logic [SLOT_W-1:0] s);
        in_word_t w;
        w.func       = f;
        w.key_hash   = h;
        w.row_number = r;
        w.generation = g;
        w.slot       = s;
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        op_tally[w.func]++;
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial
    begin
        in_word_t w;
        int       pick;
        int       real_ops;
        int       spare_total;
        for (int i = 0; i < HASH_POOL; i++)
            hash_pool[i] = random_hash();
        for (int i = 0; i < TOKEN_POOL; i++) begin
            token_row[i] = ROW_BITS'($urandom());
            token_gen[i] = GEN_BITS'($urandom());
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, slot reuse, empty targets, replacement and spare codes.
        send_word(make_word(FUNC_LOOKUP, '1, '0, '0, '0));
        send_word(make_word(FUNC_RECORD, '0, '0, '0, '0));
        send_word(make_word(FUNC_RECORD, '1, '1, '1, '1));
        send_word(make_word(FUNC_LOOKUP, '0, '0, '0, '0));
        send_word(make_word(FUNC_LOOKUP, '1, '0, '0, '1));
        send_word(make_word(FUNC_LOOKUP, '1, '0, '0, '1 - 1'b0));
        send_word(make_word(FUNC_RECORD, 64'h5555_AAAA_5555_AAAA, '1, '1, '0));
        send_word(make_word(FUNC_BUMP, '0, '0, '0, 3'd0));
        send_word(make_word(FUNC_BUMP, '0, '0, '0, '1));
        send_word(make_word(FUNC_EVICT, '0, '0, '0, '1));
        send_word(make_word(FUNC_EVICT, '0, '0, '0, 3'd0));
        send_word(make_word(FUNC_LOOKUP, '0, '0, '0, '0));
        for (int i = 0; i < ENTRIES; i++)
            send_word(make_word(FUNC_RECORD, 64'hA5A5_0000_0000_0000 | (i % 4),
                                16'(i), 32'(i + 100), '0));
        send_word(make_word(FUNC_LOOKUP, 64'hA5A5_0000_0000_0001, '0, '0, 3'd2));
        for (int f = FUNC_UNUSED_FIRST; f <= FUNC_UNUSED_LAST; f++)
            send_word(make_word(f[FUNC_W-1:0], '1, '1, '1, '1));
        send_word(make_word(FUNC_CLEAR, '1, '1, '1, '1));
        send_word(make_word(FUNC_LOOKUP, '0, '0, '0, '0));

        // Fill the cache, age all but the last slot, then force replacements.
        for (int i = 0; i < ENTRIES; i++)
            send_word(make_word(FUNC_RECORD, hash_pool[i], token_row[i], token_gen[i], '0));
        for (int n = 0; n < AGING_BUMPS; n++)
            send_word(make_word(FUNC_BUMP, random_hash(), ROW_BITS'($urandom()),
                                GEN_BITS'($urandom()),
                                SLOT_W'($urandom_range(0, ENTRIES - 2))));
        for (int i = 0; i < 4; i++) begin
            send_word(make_word(FUNC_RECORD, random_hash(), ROW_BITS'($urandom()),
                                GEN_BITS'($urandom()), '0));
            send_word(make_word(FUNC_LOOKUP, hash_pool[i], '0, '0, '0));
        end

        real_ops = 0;
        while (real_ops < RANDOM_ITEMS) begin
            w = make_word('0, random_hash(), ROW_BITS'($urandom()), GEN_BITS'($urandom()),
                          SLOT_W'($urandom()));
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                w.func = FUNC_RECORD;
                if ($urandom_range(0, 1) == 1) begin
                    pick         = $urandom_range(0, TOKEN_POOL - 1);
                    w.row_number = token_row[pick];
                    w.generation = token_gen[pick];
                end
                if ($urandom_range(0, 9) < 7)
                    w.key_hash = hash_pool[$urandom_range(0, HASH_POOL - 1)];
            end
            else if (pick < 55) begin
                w.func     = FUNC_LOOKUP;
                w.key_hash = hash_pool[$urandom_range(0, HASH_POOL - 1)];
            end
            else if (pick < 70) begin
                w.func = FUNC_BUMP;
            end
            else if (pick < 82) begin
                w.func = FUNC_EVICT;
            end
            else if (pick < 84) begin
                w.func = FUNC_CLEAR;
            end
            else if (pick < 88) begin
                w.func = FUNC_W'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
            end
            else begin
                w.func = FUNC_LOOKUP;
            end
            if ($urandom_range(0, 19) == 0)
                hash_pool[$urandom_range(0, HASH_POOL - 1)] = random_hash();
            if ($urandom_range(0, 29) == 0) begin
                pick            = $urandom_range(0, TOKEN_POOL - 1);
                token_row[pick] = ROW_BITS'($urandom());
                token_gen[pick] = GEN_BITS'($urandom());
            end
            send_word(w);
            if (w.func <= FUNC_CLEAR)
                real_ops++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (replies_awaited != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        spare_total = 0;
        for (int f = FUNC_UNUSED_FIRST; f <= FUNC_UNUSED_LAST; f++)
            spare_total += op_tally[f];
        $display("Sent %0d lookups, %0d bumps, %0d evicts, %0d records, %0d clears, %0d spare codes.",
                 op_tally[FUNC_LOOKUP], op_tally[FUNC_BUMP], op_tally[FUNC_EVICT],
                 op_tally[FUNC_RECORD], op_tally[FUNC_CLEAR], spare_total);
        $display("Compared %0d replies under random input gaps and output stalls; %0d mismatches.",
                 replies_checked, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
